@@ rtl/tlbpt_pkg.sv @@
package tlbpt_pkg;

    localparam int OFFSET_WIDTH = 12;
    localparam int VADDR_WIDTH  = 20;
    localparam int PAGE_BITS    = VADDR_WIDTH - OFFSET_WIDTH;
    localparam int PAGE_COUNT   = 1 << PAGE_BITS;
    localparam int FRAME_COUNT  = 8;
    localparam int FRAME_BITS   = $clog2(FRAME_COUNT);
    localparam int TLB_DEPTH    = 8;
    localparam int TLB_BITS     = $clog2(TLB_DEPTH);
    localparam int PADDR_WIDTH  = 15;
    localparam int QUEUE_DEPTH  = 2;
    localparam int SWEEP_LIMIT  = 2 * FRAME_COUNT + 1;
    localparam int SWEEP_BITS   = $clog2(SWEEP_LIMIT + 1);

    typedef enum logic [1:0] {
        MODE_FIFO  = 2'd0,
        MODE_LRU   = 2'd1,
        MODE_CLOCK = 2'd2,
        MODE_CLK3  = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_SWEEP,
        ST_COMMIT,
        ST_OUT
    } t_state;

    // Front end forwards the page and offset of one accepted request.
    typedef struct packed {
        logic [PAGE_BITS-1:0]    page;
        logic [OFFSET_WIDTH-1:0] offset;
    } t_req;

    typedef struct packed {
        logic [PADDR_WIDTH-1:0] physical_address;
        logic                   tlb_hit;
        logic                   page_fault;
        logic                   evicted;
        logic [7:0]             evicted_page;
    } t_result;

endpackage

@@ rtl/tlb_page_table_translator_top.sv @@
// TLB and demand-paged address translator.
// Slave channel: one 20-bit virtual address per transaction (page in the
// upper 8 bits, offset in the lower 12). Master channel: one result per
// transaction with the 15-bit physical address and hit/fault/evict flags.
// The mode register (i_cfg_we/i_cfg_data) selects FIFO, LRU or clock
// replacement; the user must write it only while the block is idle, unenforced.
// A two-entry queue decouples acceptance from the translation engine, so
// up to two addresses are taken while a result waits.
// A TLB hit, page-table hit, free-frame fault, or FIFO/LRU eviction goes from
// the queue through IDLE, LOOKUP, COMMIT and OUT; a clock eviction adds a SWEEP
// state for each hand step, up to 17 hand steps. The engine handles one
// transaction at a time, taking no new address until the last result is taken.
// Reset clears the TLB, page-table valid bits and all policy state. When the
// receiver stalls the result holds in the output register and the engine
// waits; the queue then fills and tready drops.
module tlb_page_table_translator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [19:0] virtual_address
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // physical_address, tlb_hit, page_fault,
                                        // evicted, evicted_page
);
    tlbpt_pkg::t_mode   r_mode;
    tlbpt_pkg::t_req    w_req;
    tlbpt_pkg::t_result w_res;
    logic               w_qv, w_pop, w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)      r_mode <= tlbpt_pkg::MODE_FIFO;
        else if (i_cfg_we) r_mode <= tlbpt_pkg::t_mode'(i_cfg_data);
    end

    tlbpt_front u_front (
        .i_clk, .i_rst_n,
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_data  (s_axis_tdata),
        .o_q_valid (w_qv),
        .i_q_pop (w_pop),
        .o_q_req (w_req)
    );

    tlbpt_back u_back (
        .i_clk, .i_rst_n,
        .i_mode  (r_mode),
        .i_q_valid (w_qv),
        .i_q_req (w_req),
        .o_q_pop (w_pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_result (w_res),
        .o_busy  (w_busy)
    );

    assign m_axis_tdata = {6'd0, w_res.evicted_page, w_res.evicted, w_res.page_fault,
                           w_res.tlb_hit, w_res.physical_address};

    a_evict_implies_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.evicted |-> w_res.page_fault)
        else $error("eviction without fault");
    a_hit_no_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && w_res.tlb_hit |-> !w_res.page_fault)
        else $error("tlb hit reported with fault");
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_busy)
        else $error("queue popped while engine busy");
endmodule

@@ rtl/tlbpt_front.sv @@
module tlbpt_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [23:0]            i_data,
    output logic                   o_q_valid,
    input  logic                   i_q_pop,
    output tlbpt_pkg::t_req        o_q_req
);
    localparam int QB = $clog2(tlbpt_pkg::QUEUE_DEPTH);

    tlbpt_pkg::t_req              r_mem [tlbpt_pkg::QUEUE_DEPTH];
    logic [QB-1:0]                r_wp, r_rp;
    logic [QB:0]                  r_cnt;
    logic                         w_push;
    tlbpt_pkg::t_req              w_req;

    assign o_ready   = (r_cnt < (QB+1)'(tlbpt_pkg::QUEUE_DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign w_push    = i_valid && o_ready;
    assign w_req.page   = i_data[tlbpt_pkg::VADDR_WIDTH-1:tlbpt_pkg::OFFSET_WIDTH];
    assign w_req.offset = i_data[tlbpt_pkg::OFFSET_WIDTH-1:0];
    assign o_q_req   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= w_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (i_q_pop && o_q_valid) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QB+1)'(w_push) - (QB+1)'(i_q_pop && o_q_valid);
        end
    end
endmodule

@@ rtl/tlbpt_back.sv @@
module tlbpt_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tlbpt_pkg::t_mode     i_mode,
    input  logic                 i_q_valid,
    input  tlbpt_pkg::t_req      i_q_req,
    output logic                 o_q_pop,
    output logic                 o_valid,
    input  logic                 i_ready,
    output tlbpt_pkg::t_result   o_result,
    output logic                 o_busy
);
    localparam int FC = tlbpt_pkg::FRAME_COUNT;
    localparam int FB = tlbpt_pkg::FRAME_BITS;
    localparam int TD = tlbpt_pkg::TLB_DEPTH;
    localparam int TB = tlbpt_pkg::TLB_BITS;
    localparam int PB = tlbpt_pkg::PAGE_BITS;
    localparam int PC = tlbpt_pkg::PAGE_COUNT;

    tlbpt_pkg::t_state r_state, n_state;

    // Page table lives in a memory with a registered read port; validity is a
    // per-page flop vector that reset clears.
    logic [FB-1:0]     r_pt_frame [PC];
    logic [PC-1:0]     r_pt_valid;
    logic [FB-1:0]     r_pt_rd;

    logic [PB-1:0]     r_owner [FC];
    logic [FC-1:0]     r_occ;
    logic [PB-1:0]     r_tag [TD];
    logic [FB-1:0]     r_tframe [TD];
    logic [TD-1:0]     r_tvalid;
    logic [TB-1:0]     r_fill;
    logic [FB-1:0]     r_fifo;
    logic [FB-1:0]     r_rank [FC];
    logic [FC-1:0]     r_ref;
    logic [FB-1:0]     r_hand;
    logic [tlbpt_pkg::SWEEP_BITS-1:0] r_steps;

    tlbpt_pkg::t_req   r_req;
    logic              r_hit;
    logic [FB-1:0]     r_hit_frame;
    logic [FB-1:0]     r_victim;
    tlbpt_pkg::t_result r_res;

    logic              w_hit;
    logic [FB-1:0]     w_hit_frame;
    logic              w_free;
    logic [FB-1:0]     w_free_frame;
    logic [FB-1:0]     w_lru;

    always_comb begin
        w_hit = 1'b0;
        w_hit_frame = '0;
        for (int i = TD - 1; i >= 0; i--) begin
            if (r_tvalid[i] && r_tag[i] == r_req.page) begin
                w_hit = 1'b1;
                w_hit_frame = r_tframe[i];
            end
        end
        w_free = 1'b0;
        w_free_frame = '0;
        for (int g = FC - 1; g >= 0; g--) begin
            if (!r_occ[g]) begin
                w_free = 1'b1;
                w_free_frame = FB'(g);
            end
        end
        w_lru = '0;
        for (int g = 1; g < FC; g++) begin
            if (r_rank[g] > r_rank[w_lru]) w_lru = FB'(g);
        end
    end

    assign o_q_pop  = (r_state == tlbpt_pkg::ST_IDLE) && i_q_valid;
    assign o_valid  = (r_state == tlbpt_pkg::ST_OUT);
    assign o_result = r_res;
    assign o_busy   = (r_state != tlbpt_pkg::ST_IDLE);

    always_comb begin
        n_state = r_state;
        case (r_state)
            tlbpt_pkg::ST_IDLE:   if (i_q_valid) n_state = tlbpt_pkg::ST_LOOKUP;
            tlbpt_pkg::ST_LOOKUP: begin
                if (w_hit || r_pt_valid[r_req.page] || w_free
                    || i_mode == tlbpt_pkg::MODE_FIFO || i_mode == tlbpt_pkg::MODE_LRU) begin
                    n_state = tlbpt_pkg::ST_COMMIT;
                end else begin
                    n_state = tlbpt_pkg::ST_SWEEP;
                end
            end
            tlbpt_pkg::ST_SWEEP: begin
                if (!r_ref[r_hand] || r_steps == tlbpt_pkg::SWEEP_BITS'(tlbpt_pkg::SWEEP_LIMIT - 1))
                    n_state = tlbpt_pkg::ST_COMMIT;
            end
            tlbpt_pkg::ST_COMMIT: n_state = tlbpt_pkg::ST_OUT;
            tlbpt_pkg::ST_OUT:    if (i_ready) n_state = tlbpt_pkg::ST_IDLE;
            default:              n_state = tlbpt_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= tlbpt_pkg::ST_IDLE;
        else          r_state <= n_state;
    end

    // Memory port of the page table: read in IDLE, written in COMMIT.
    always_ff @(posedge i_clk) begin
        if (r_state == tlbpt_pkg::ST_IDLE) r_pt_rd <= r_pt_frame[i_q_req.page];
        if (r_state == tlbpt_pkg::ST_COMMIT && !r_hit && !r_pt_valid[r_req.page])
            r_pt_frame[r_req.page] <= r_victim;
    end

    always_ff @(posedge i_clk) begin
        logic [FB-1:0] f;
        logic          fault;
        logic          was;
        logic [FB-1:0] old;
        logic [PB-1:0] evp;
        if (!i_rst_n) begin
            r_pt_valid <= '0;
            r_occ      <= '0;
            r_tvalid   <= '0;
            r_fill     <= '0;
            r_fifo     <= '0;
            r_ref      <= '0;
            r_hand     <= '0;
            r_steps    <= '0;
            for (int g = 0; g < FC; g++) begin
                r_owner[g] <= '0;
                r_rank[g]  <= '0;
            end
            for (int i = 0; i < TD; i++) begin
                r_tag[i]    <= '0;
                r_tframe[i] <= '0;
            end
        end else begin
            case (r_state)
                tlbpt_pkg::ST_IDLE: begin
                    if (i_q_valid) r_req <= i_q_req;
                    r_steps <= '0;
                end
                tlbpt_pkg::ST_LOOKUP: begin
                    r_hit       <= w_hit;
                    r_hit_frame <= w_hit_frame;
                    if (w_free) begin
                        r_victim <= w_free_frame;
                    end else if (i_mode == tlbpt_pkg::MODE_FIFO) begin
                        r_victim <= r_fifo;
                    end else begin
                        r_victim <= w_lru;
                    end
                    if (!w_hit && !r_pt_valid[r_req.page] && !w_free
                        && i_mode == tlbpt_pkg::MODE_FIFO) begin
                        r_fifo <= r_fifo + 1'b1;
                    end
                end
                tlbpt_pkg::ST_SWEEP: begin
                    r_steps <= r_steps + 1'b1;
                    r_hand  <= r_hand + 1'b1;
                    if (!r_ref[r_hand]) begin
                        r_victim <= r_hand;
                    end else begin
                        r_ref[r_hand] <= 1'b0;
                        // Fallback after a full sweep: the hand's final spot.
                        r_victim <= r_hand + 1'b1;
                    end
                end
                tlbpt_pkg::ST_COMMIT: begin
                    fault = !r_hit && !r_pt_valid[r_req.page];
                    f     = r_hit ? r_hit_frame : (fault ? r_victim : r_pt_rd);
                    evp   = '0;
                    r_res.tlb_hit    <= r_hit;
                    r_res.page_fault <= fault;
                    r_res.evicted    <= fault && (&r_occ);
                    r_res.physical_address <= tlbpt_pkg::PADDR_WIDTH'(
                        {f, r_req.offset});
                    if (fault && (&r_occ)) begin
                        evp = r_owner[r_victim];
                        r_pt_valid[evp] <= 1'b0;
                        for (int i = 0; i < TD; i++)
                            if (r_tvalid[i] && r_tag[i] == evp) r_tvalid[i] <= 1'b0;
                    end
                    r_res.evicted_page <= 8'(evp);
                    if (r_hit || fault) begin
                        was = r_occ[f];
                        old = r_rank[f];
                        for (int g = 0; g < FC; g++)
                            if (FB'(g) != f && r_occ[g] && (!was || r_rank[g] < old))
                                r_rank[g] <= r_rank[g] + 1'b1;
                        r_rank[f] <= '0;
                        r_ref[f]  <= 1'b1;
                    end
                    if (fault) begin
                        r_occ[f]   <= 1'b1;
                        r_owner[f] <= r_req.page;
                        r_pt_valid[r_req.page] <= 1'b1;
                    end
                    if (!r_hit) begin
                        r_tag[r_fill]    <= r_req.page;
                        r_tframe[r_fill] <= f;
                        r_tvalid[r_fill] <= 1'b1;
                        r_fill <= r_fill + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
